// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the RTL. Define NO_ASSERTIONS to
// compile them away.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/tcc_pkg.sv =====
// ---------------------------------------------------------------------------
// Triangle circumcircle package
// Shared widths, parameter defaults and the control word carried by cells.
// ---------------------------------------------------------------------------
package tcc_pkg;

  localparam int COORD_WIDTH_DEF = 12;
  localparam int FRAC_BITS_DEF   = 8;

  // Output word width and squared radius width.
  localparam int OUT_WIDTH  = 32;
  localparam int RAD_WIDTH  = 2 * OUT_WIDTH;
  localparam int ROOT_STEPS = OUT_WIDTH;

  // Centre offset is clamped to +-2^REL_LIM_LOG2 and held signed.
  localparam int REL_LIM_LOG2 = 48;
  localparam int REL_WIDTH    = REL_LIM_LOG2 + 2;

  // Divider widths at the default coordinate width.
  localparam int DEN_W_DEF = 2 * COORD_WIDTH_DEF + 2;
  localparam int QUO_W_DEF = 3 * COORD_WIDTH_DEF + 2 + FRAC_BITS_DEF;

  // Control word that travels alongside each beat.
  typedef struct packed {
    logic valid;
    logic deg;
    logic negx;
    logic negy;
    logic sat;
    logic big;
  } tcc_ctl_t;

endpackage

// ===== rtl/tcc_div_cell.sv =====
// ---------------------------------------------------------------------------
// Divider cell
// One restoring division step for the x and y quotients, registered.
// ---------------------------------------------------------------------------
module tcc_div_cell #(
  parameter int DEN_W   = tcc_pkg::DEN_W_DEF,
  parameter int QUO_W   = tcc_pkg::QUO_W_DEF,
  parameter int COORD_W = tcc_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  tcc_pkg::tcc_ctl_t          ctl_in,
  input  logic [DEN_W-1:0]           den_in,
  input  logic [DEN_W-1:0]           remx_in,
  input  logic [DEN_W-1:0]           remy_in,
  input  logic [QUO_W-1:0]           workx_in,
  input  logic [QUO_W-1:0]           worky_in,
  input  logic signed [COORD_W-1:0]  ax_in,
  input  logic signed [COORD_W-1:0]  ay_in,
  output tcc_pkg::tcc_ctl_t          ctl_out,
  output logic [DEN_W-1:0]           den_out,
  output logic [DEN_W-1:0]           remx_out,
  output logic [DEN_W-1:0]           remy_out,
  output logic [QUO_W-1:0]           workx_out,
  output logic [QUO_W-1:0]           worky_out,
  output logic signed [COORD_W-1:0]  ax_out,
  output logic signed [COORD_W-1:0]  ay_out
);
  import tcc_pkg::*;

  logic [DEN_W:0] shx, shy, difx, dify;
  logic           qbx, qby;

  // Bring down the next dividend bit and try the subtraction.
  always_comb begin
    shx  = {remx_in, workx_in[QUO_W-1]};
    shy  = {remy_in, worky_in[QUO_W-1]};
    difx = shx - {1'b0, den_in};
    dify = shy - {1'b0, den_in};
    qbx  = (shx >= {1'b0, den_in});
    qby  = (shy >= {1'b0, den_in});
  end

  // Control word.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  // Partial remainders; quotient bits shift in behind the dividend.
  always_ff @(posedge clk) begin
    if (en) begin
      den_out   <= den_in;
      remx_out  <= qbx ? difx[DEN_W-1:0] : shx[DEN_W-1:0];
      remy_out  <= qby ? dify[DEN_W-1:0] : shy[DEN_W-1:0];
      workx_out <= {workx_in[QUO_W-2:0], qbx};
      worky_out <= {worky_in[QUO_W-2:0], qby};
      ax_out    <= ax_in;
      ay_out    <= ay_in;
    end
  end

endmodule

// ===== rtl/tcc_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// Square root cell
// One digit step of the integer square root of the squared radius.
// ---------------------------------------------------------------------------
module tcc_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  tcc_pkg::tcc_ctl_t                    ctl_in,
  input  logic [tcc_pkg::RAD_WIDTH-1:0]        s_in,
  input  logic [tcc_pkg::RAD_WIDTH-1:0]        res_in,
  input  logic [tcc_pkg::OUT_WIDTH-1:0]        cx_in,
  input  logic [tcc_pkg::OUT_WIDTH-1:0]        cy_in,
  output tcc_pkg::tcc_ctl_t                    ctl_out,
  output logic [tcc_pkg::RAD_WIDTH-1:0]        s_out,
  output logic [tcc_pkg::RAD_WIDTH-1:0]        res_out,
  output logic [tcc_pkg::OUT_WIDTH-1:0]        cx_out,
  output logic [tcc_pkg::OUT_WIDTH-1:0]        cy_out
);
  import tcc_pkg::*;

  localparam logic [RAD_WIDTH-1:0] BIT_VAL = RAD_WIDTH'(1) << (2 * STEP);

  logic [RAD_WIDTH:0] trial;
  logic               take;

  // Try to take the current digit.
  always_comb begin
    trial = {1'b0, res_in} + {1'b0, BIT_VAL};
    take  = ({1'b0, s_in} >= trial);
  end

  // Control word.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  // Remaining radicand and partial root.
  always_ff @(posedge clk) begin
    if (en) begin
      s_out   <= take ? s_in - trial[RAD_WIDTH-1:0] : s_in;
      res_out <= take ? (res_in >> 1) + BIT_VAL : res_in >> 1;
      cx_out  <= cx_in;
      cy_out  <= cy_in;
    end
  end

endmodule

// ===== rtl/triangle_circumcircle_unit.sv =====
// ---------------------------------------------------------------------------
// Triangle circumcircle unit
// Circumcentre and circumradius of one integer triangle per beat.
// ---------------------------------------------------------------------------
// Usage: present a triangle (ax, ay, bx, by_coord, qx, qy) with in_valid; a
// beat is taken at a clock edge where in_valid is high and in_stall is low.
// Results leave on center_x, center_y, circle_radius, degenerate and
// saturated with out_valid, taken where out_stall is low.
// The chain is seven front stages, one divider cell per quotient bit, four
// post stages, 32 square root cells and the output register.
// Throughput is one triangle per cycle while the chain is not frozen; every
// cell takes a new beat each such cycle.
// When the output holds a result and out_stall is high the whole chain
// freezes and in_stall rises in the same cycle; nothing is lost.
// Reset clears every valid bit; payload registers are not reset.
// A collinear triangle gives degenerate with all other outputs zero.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_circumcircle_unit #(
  parameter int COORD_WIDTH = tcc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = tcc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       ax,
  input  logic signed [COORD_WIDTH-1:0]       ay,
  input  logic signed [COORD_WIDTH-1:0]       bx,
  input  logic signed [COORD_WIDTH-1:0]       by_coord,
  input  logic signed [COORD_WIDTH-1:0]       qx,
  input  logic signed [COORD_WIDTH-1:0]       qy,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tcc_pkg::OUT_WIDTH-1:0] center_x,
  output logic signed [tcc_pkg::OUT_WIDTH-1:0] center_y,
  output logic [tcc_pkg::OUT_WIDTH-1:0]       circle_radius,
  output logic                                degenerate,
  output logic                                saturated
);
  import tcc_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int UW   = CW + 1;
  localparam int PW   = 2 * UW;
  localparam int DW   = PW + 1;
  localparam int NUW  = 2 * CW + 1;
  localparam int PPW  = 2 * UW + 1;
  localparam int NSW  = 3 * CW + 3;
  localparam int NM   = 3 * CW + 2;
  localparam int DM   = 2 * CW + 2;
  localparam int QW   = NM + FRAC_BITS;
  localparam int QE   = (QW + 1 > REL_WIDTH) ? QW + 1 : REL_WIDTH;
  localparam int SUMW = REL_WIDTH + 1;

  logic en;

  // Front stage registers.
  logic                 v1, v2, v3, v4, v5, v6;
  logic signed [CW-1:0] ax1, ay1, ax2, ay2, ax3, ay3, ax4, ay4, ax5, ay5, ax6, ay6;
  logic signed [UW-1:0] ux1, uy1, vx1, vy1, ux2, uy2, vx2, vy2, ux3, uy3, vx3, vy3;
  logic signed [PW-1:0] pa2, pb2, sux2, suy2, svx2, svy2;
  logic signed [DW-1:0] d3, d4, d5, d6;
  logic [NUW-1:0]       nu3, nv3;
  logic signed [PPW-1:0] vynl4, vynh4, uynl4, uynh4, uxnl4, uxnh4, vxnl4, vxnh4;
  logic signed [NSW-1:0] tvnu5, tunv5, tunv5b, tvxnu5, numx6, numy6;

  // Divider chain.
  tcc_ctl_t             ctl_d   [QW+1];
  logic [DM-1:0]        den_d   [QW+1];
  logic [DM-1:0]        remx_d  [QW+1];
  logic [DM-1:0]        remy_d  [QW+1];
  logic [QW-1:0]        workx_d [QW+1];
  logic [QW-1:0]        worky_d [QW+1];
  logic signed [CW-1:0] ax_d    [QW+1];
  logic signed [CW-1:0] ay_d    [QW+1];

  // Post stages.
  tcc_ctl_t                     ctl_p1, ctl_p2, ctl_p3;
  logic signed [REL_WIDTH-1:0]  relx_p1, rely_p1;
  logic signed [CW-1:0]         ax_p1, ay_p1;
  logic [OUT_WIDTH-1:0]         cx_p2, cy_p2, cx_p3, cy_p3;
  logic [OUT_WIDTH-1:0]         mx_p2, my_p2;
  logic [RAD_WIDTH-1:0]         sqx_p3, sqy_p3;

  // Square root chain.
  tcc_ctl_t             ctl_s [ROOT_STEPS+1];
  logic [RAD_WIDTH-1:0] s_s   [ROOT_STEPS+1];
  logic [RAD_WIDTH-1:0] res_s [ROOT_STEPS+1];
  logic [OUT_WIDTH-1:0] cx_s  [ROOT_STEPS+1];
  logic [OUT_WIDTH-1:0] cy_s  [ROOT_STEPS+1];

  // Rounded and clamped quotient, signed.
  function automatic logic signed [REL_WIDTH-1:0] round_rel(
    input logic [QW-1:0] quo,
    input logic [DM-1:0] rem,
    input logic [DM-1:0] den,
    input logic          neg
  );
    logic [QE-1:0] q;
    logic [QE-1:0] lim;
    logic [REL_WIDTH-1:0] mag;
    q   = QE'(quo) + QE'({rem, 1'b0} >= {1'b0, den});
    lim = QE'(1) << REL_LIM_LOG2;
    mag = (q >= lim) ? REL_WIDTH'(lim) : REL_WIDTH'(q);
    round_rel = neg ? -$signed(mag) : $signed(mag);
  endfunction

  // The chain moves unless a finished result is held up.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid; v2 <= v1; v3 <= v2;
      v4 <= v3; v5 <= v4; v6 <= v5;
    end
  end

  // Front datapath: edges, products, area and norms, numerators.
  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= ax; ay1 <= ay;
      ux1 <= UW'(bx) - UW'(ax);
      uy1 <= UW'(by_coord) - UW'(ay);
      vx1 <= UW'(qx) - UW'(ax);
      vy1 <= UW'(qy) - UW'(ay);

      ax2 <= ax1; ay2 <= ay1;
      ux2 <= ux1; uy2 <= uy1; vx2 <= vx1; vy2 <= vy1;
      pa2  <= ux1 * vy1;
      pb2  <= uy1 * vx1;
      sux2 <= ux1 * ux1;
      suy2 <= uy1 * uy1;
      svx2 <= vx1 * vx1;
      svy2 <= vy1 * vy1;

      ax3 <= ax2; ay3 <= ay2;
      ux3 <= ux2; uy3 <= uy2; vx3 <= vx2; vy3 <= vy2;
      d3  <= $signed({pa2 - pb2, 1'b0});
      nu3 <= NUW'(sux2 + suy2);
      nv3 <= NUW'(svx2 + svy2);

      ax4 <= ax3; ay4 <= ay3; d4 <= d3;
      vynl4 <= vy3 * $signed({1'b0, nu3[UW-1:0]});
      vynh4 <= vy3 * $signed({1'b0, nu3[NUW-1:UW]});
      uynl4 <= uy3 * $signed({1'b0, nv3[UW-1:0]});
      uynh4 <= uy3 * $signed({1'b0, nv3[NUW-1:UW]});
      uxnl4 <= ux3 * $signed({1'b0, nv3[UW-1:0]});
      uxnh4 <= ux3 * $signed({1'b0, nv3[NUW-1:UW]});
      vxnl4 <= vx3 * $signed({1'b0, nu3[UW-1:0]});
      vxnh4 <= vx3 * $signed({1'b0, nu3[NUW-1:UW]});

      ax5 <= ax4; ay5 <= ay4; d5 <= d4;
      tvnu5  <= (NSW'(vynh4) <<< UW) + NSW'(vynl4);
      tunv5  <= (NSW'(uynh4) <<< UW) + NSW'(uynl4);
      tunv5b <= (NSW'(uxnh4) <<< UW) + NSW'(uxnl4);
      tvxnu5 <= (NSW'(vxnh4) <<< UW) + NSW'(vxnl4);

      ax6 <= ax5; ay6 <= ay5; d6 <= d5;
      numx6 <= tvnu5 - tunv5;
      numy6 <= tunv5b - tvxnu5;
    end
  end

  tcc_ctl_t ctl_d0_next;

  // Divider entry: magnitudes, signs and the collinear check.
  always_comb begin
    ctl_d0_next.valid = v6;
    ctl_d0_next.deg   = (d6 == '0);
    ctl_d0_next.negx  = numx6[NSW-1] ^ d6[DW-1];
    ctl_d0_next.negy  = numy6[NSW-1] ^ d6[DW-1];
    ctl_d0_next.sat   = 1'b0;
    ctl_d0_next.big   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d[0] <= '0;
    end else if (en) begin
      ctl_d[0] <= ctl_d0_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_d[0]   <= d6[DW-1] ? DM'(-d6) : DM'(d6);
      remx_d[0]  <= '0;
      remy_d[0]  <= '0;
      workx_d[0] <= QW'(numx6[NSW-1] ? NM'(-numx6) : NM'(numx6)) << FRAC_BITS;
      worky_d[0] <= QW'(numy6[NSW-1] ? NM'(-numy6) : NM'(numy6)) << FRAC_BITS;
      ax_d[0]    <= ax6;
      ay_d[0]    <= ay6;
    end
  end

  // One divider cell per quotient bit.
  for (genvar i = 0; i < QW; i++) begin : g_div
    tcc_div_cell #(
      .DEN_W   (DM),
      .QUO_W   (QW),
      .COORD_W (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .ctl_in    (ctl_d[i]),
      .den_in    (den_d[i]),
      .remx_in   (remx_d[i]),
      .remy_in   (remy_d[i]),
      .workx_in  (workx_d[i]),
      .worky_in  (worky_d[i]),
      .ax_in     (ax_d[i]),
      .ay_in     (ay_d[i]),
      .ctl_out   (ctl_d[i+1]),
      .den_out   (den_d[i+1]),
      .remx_out  (remx_d[i+1]),
      .remy_out  (remy_d[i+1]),
      .workx_out (workx_d[i+1]),
      .worky_out (worky_d[i+1]),
      .ax_out    (ax_d[i+1]),
      .ay_out    (ay_d[i+1])
    );
  end

  logic signed [SUMW-1:0] cxf, cyf;
  logic [REL_WIDTH-2:0]   mxf, myf;
  logic                   satx, saty, bigx, bigy;
  logic [RAD_WIDTH:0]     ssum;
  tcc_ctl_t               ctl_p2_next, ctl_s0_next;

  // Centre sum, clipping checks and offset magnitudes.
  always_comb begin
    cxf  = (SUMW'(ax_p1) <<< FRAC_BITS) + SUMW'(relx_p1);
    cyf  = (SUMW'(ay_p1) <<< FRAC_BITS) + SUMW'(rely_p1);
    satx = !((&cxf[SUMW-1:OUT_WIDTH-1]) || !(|cxf[SUMW-1:OUT_WIDTH-1]));
    saty = !((&cyf[SUMW-1:OUT_WIDTH-1]) || !(|cyf[SUMW-1:OUT_WIDTH-1]));
    mxf  = relx_p1[REL_WIDTH-1] ? (REL_WIDTH-1)'(-relx_p1) : (REL_WIDTH-1)'(relx_p1);
    myf  = rely_p1[REL_WIDTH-1] ? (REL_WIDTH-1)'(-rely_p1) : (REL_WIDTH-1)'(rely_p1);
    bigx = |mxf[REL_WIDTH-2:OUT_WIDTH];
    bigy = |myf[REL_WIDTH-2:OUT_WIDTH];
    ssum = {1'b0, sqx_p3} + {1'b0, sqy_p3};

    ctl_p2_next     = ctl_p1;
    ctl_p2_next.sat = satx || saty;
    ctl_p2_next.big = bigx || bigy;
    ctl_s0_next     = ctl_p3;
    ctl_s0_next.big = ctl_p3.big || ssum[RAD_WIDTH];
  end

  // Post stage control words.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p1   <= '0;
      ctl_p2   <= '0;
      ctl_p3   <= '0;
      ctl_s[0] <= '0;
    end else if (en) begin
      ctl_p1   <= ctl_d[QW];
      ctl_p2   <= ctl_p2_next;
      ctl_p3   <= ctl_p2;
      ctl_s[0] <= ctl_s0_next;
    end
  end

  // Post datapath: rounding, centre, squared radius.
  always_ff @(posedge clk) begin
    if (en) begin
      relx_p1 <= round_rel(workx_d[QW], remx_d[QW], den_d[QW], ctl_d[QW].negx);
      rely_p1 <= round_rel(worky_d[QW], remy_d[QW], den_d[QW], ctl_d[QW].negy);
      ax_p1   <= ax_d[QW];
      ay_p1   <= ay_d[QW];

      cx_p2 <= satx ? {cxf[SUMW-1], {(OUT_WIDTH-1){!cxf[SUMW-1]}}} : cxf[OUT_WIDTH-1:0];
      cy_p2 <= saty ? {cyf[SUMW-1], {(OUT_WIDTH-1){!cyf[SUMW-1]}}} : cyf[OUT_WIDTH-1:0];
      mx_p2 <= mxf[OUT_WIDTH-1:0];
      my_p2 <= myf[OUT_WIDTH-1:0];

      cx_p3  <= cx_p2;
      cy_p3  <= cy_p2;
      sqx_p3 <= mx_p2 * mx_p2;
      sqy_p3 <= my_p2 * my_p2;

      s_s[0]   <= ssum[RAD_WIDTH-1:0];
      res_s[0] <= '0;
      cx_s[0]  <= cx_p3;
      cy_s[0]  <= cy_p3;
    end
  end

  // One square root cell per result bit, top digit first.
  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
    tcc_sqrt_cell #(
      .STEP (ROOT_STEPS - 1 - k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl_s[k]),
      .s_in    (s_s[k]),
      .res_in  (res_s[k]),
      .cx_in   (cx_s[k]),
      .cy_in   (cy_s[k]),
      .ctl_out (ctl_s[k+1]),
      .s_out   (s_s[k+1]),
      .res_out (res_s[k+1]),
      .cx_out  (cx_s[k+1]),
      .cy_out  (cy_s[k+1])
    );
  end

  logic [OUT_WIDTH:0] rr;
  tcc_ctl_t           ctl_f;

  // Round the root to nearest.
  always_comb begin
    ctl_f = ctl_s[ROOT_STEPS];
    rr    = {1'b0, res_s[ROOT_STEPS][OUT_WIDTH-1:0]}
          + (OUT_WIDTH+1)'(s_s[ROOT_STEPS] > res_s[ROOT_STEPS]);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_f.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_f.deg) begin
        center_x      <= '0;
        center_y      <= '0;
        circle_radius <= '0;
        degenerate    <= 1'b1;
        saturated     <= 1'b0;
      end else begin
        center_x      <= $signed(cx_s[ROOT_STEPS]);
        center_y      <= $signed(cy_s[ROOT_STEPS]);
        circle_radius <= (ctl_f.big || rr[OUT_WIDTH]) ? '1 : rr[OUT_WIDTH-1:0];
        degenerate    <= 1'b0;
        saturated     <= ctl_f.sat || ctl_f.big || rr[OUT_WIDTH];
      end
    end
  end

  // A collinear result carries nothing else.
  `ASSERT_IMPLY(a_deg_clear, clk, rst, out_valid && degenerate, center_x == '0 && center_y == '0 && circle_radius == '0 && !saturated, "degenerate result with nonzero fields")
  // A held result freezes the input side too.
  `ASSERT_IMPLY(a_hold_input, clk, rst, out_valid && out_stall, in_stall, "input taken while output held")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Triangle circumcircle unit testbench
// Drives triangles through the unit under random source gaps and sink stalls.
// A directed table goes first. Its rows cover extremes, collinear and
// near-collinear triangles, overflow of the centre and overflow of the radius.
// Random triangles follow. Every result beat is checked against an integer
// predictor of the centre and radius.
// ---------------------------------------------------------------------------
module testbench;
  import tcc_pkg::*;

  localparam int CW       = 12;
  localparam int FB       = 8;
  localparam int N_RANDOM = 880;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] cx;
    logic signed [OUT_WIDTH-1:0] cy;
    logic [OUT_WIDTH-1:0]        rad;
    logic                        deg;
    logic                        sat;
  } circle_t;

  typedef struct {
    coord_t  v[6];
    bit      typed;
    circle_t want;
  } tri_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  coord_t ax = '0, ay = '0, bx = '0, by_coord = '0, qx = '0, qy = '0;
  logic in_stall, out_valid, degenerate, saturated;
  logic signed [OUT_WIDTH-1:0] center_x, center_y;
  logic [OUT_WIDTH-1:0] circle_radius;

  circle_t pending_circles[$];
  int      mismatches = 0;
  int      src_idle_pct = 24;
  int      snk_stall_pct = 71;

  triangle_circumcircle_unit #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord), .qx(qx), .qy(qy),
    .out_valid(out_valid), .out_stall(out_stall),
    .center_x(center_x), .center_y(center_y), .circle_radius(circle_radius),
    .degenerate(degenerate), .saturated(saturated)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Rounded quotient (num * 2^FB) / d, half away from zero, clamped to 2^48.
  function automatic longint centre_offset(longint num, longint d);
    longint lim;
    longint mg;
    longint den;
    longint q;
    longint rem;
    bit     neg;
    lim = longint'(1) << REL_LIM_LOG2;
    neg = (num < 0) != (d < 0);
    mg  = (num < 0 ? -num : num) <<< FB;
    den = d < 0 ? -d : d;
    q   = mg / den;
    rem = mg % den;
    if (rem >= den - rem) q = q + 1;
    if (q >= lim) q = lim;
    return neg ? -q : q;
  endfunction

  function automatic logic [63:0] floor_root(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s   = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clip32(longint x, ref bit f);
    if (x > 64'sd2147483647) begin
      f = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      f = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  // Circumcentre and circumradius of one triangle.
  function automatic circle_t circumcircle(coord_t v[6]);
    circle_t     c;
    longint      pax, pay, ux, uy, vx, vy, d, nu, nv, rx, ry, cx, cy;
    logic [63:0] mx, my, r, top;
    logic [64:0] s;
    bit          f;
    pax = v[0];
    pay = v[1];
    ux  = longint'(v[2]) - pax;
    uy  = longint'(v[3]) - pay;
    vx  = longint'(v[4]) - pax;
    vy  = longint'(v[5]) - pay;
    d   = 2 * (ux * vy - uy * vx);
    c   = '{0, 0, 0, 1'b0, 1'b0};
    f   = 1'b0;
    top = 64'hFFFF_FFFF;
    if (d == 0) begin
      c.deg = 1'b1;
      return c;
    end
    nu = ux * ux + uy * uy;
    nv = vx * vx + vy * vy;
    rx = centre_offset(vy * nu - uy * nv, d);
    ry = centre_offset(ux * nv - vx * nu, d);
    cx = clip32(pax * (longint'(1) << FB) + rx, f);
    cy = clip32(pay * (longint'(1) << FB) + ry, f);
    mx = rx < 0 ? -rx : rx;
    my = ry < 0 ? -ry : ry;
    if (mx > top || my > top) begin
      f = 1'b1;
      r = top;
    end else begin
      s = {1'b0, mx * mx} + {1'b0, my * my};
      if (s[64]) begin
        f = 1'b1;
        r = top;
      end else begin
        r = floor_root(s[63:0]);
        if (s[63:0] - r * r > r) r = r + 1;
        if (r > top) begin
          f = 1'b1;
          r = top;
        end
      end
    end
    c.cx  = cx[31:0];
    c.cy  = cy[31:0];
    c.rad = r[31:0];
    c.sat = f;
    return c;
  endfunction

  task automatic report(string what, longint got, longint want);
    mismatches++;
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Predict on each accepted triangle; check each accepted result beat.
  always @(posedge clk) begin
    circle_t e;
    coord_t  v[6];
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_circles.size() == 0) begin
          report("unexpected result beat", 0, 0);
        end else begin
          e = pending_circles.pop_front();
          if (center_x !== e.cx) report("center_x", center_x, e.cx);
          if (center_y !== e.cy) report("center_y", center_y, e.cy);
          if (circle_radius !== e.rad) report("circle_radius", circle_radius, e.rad);
          if (degenerate !== e.deg) report("degenerate", degenerate, e.deg);
          if (saturated !== e.sat) report("saturated", saturated, e.sat);
        end
      end
      if (in_valid && !in_stall) begin
        v = '{ax, ay, bx, by_coord, qx, qy};
        pending_circles.push_back(circumcircle(v));
      end
    end
  end

  // Sink stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < snk_stall_pct);
  end

  task automatic send_triangle(coord_t v[6]);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    ax <= v[0]; ay <= v[1]; bx <= v[2]; by_coord <= v[3]; qx <= v[4]; qy <= v[5];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random triangle: mostly general, some collinear, some nearly collinear.
  function automatic void random_triangle(ref coord_t v[6]);
    int kind, dx, dy, k, x0, y0;
    kind = $urandom_range(9);
    if (kind < 5) begin
      foreach (v[i]) v[i] = coord_t'($urandom);
    end else if (kind < 7) begin
      x0 = $urandom_range(1000) - 500;
      y0 = $urandom_range(1000) - 500;
      foreach (v[i]) v[i] = coord_t'((i % 2 ? y0 : x0) + $urandom_range(40) - 20);
    end else begin
      x0 = $urandom_range(1000) - 500;
      y0 = $urandom_range(1000) - 500;
      dx = $urandom_range(600) - 300;
      dy = $urandom_range(600) - 300;
      k  = $urandom_range(6) - 3;
      v  = '{coord_t'(x0), coord_t'(y0), coord_t'(x0 + dx), coord_t'(y0 + dy),
             coord_t'(x0 + k * dx + (kind == 9 ? 1 : 0)), coord_t'(y0 + k * dy)};
    end
  endfunction

  tri_row_t directed[$];

  initial begin
    coord_t  v[6];
    circle_t zero_deg;
    int      wait_cycles;
    zero_deg = '{0, 0, 0, 1'b1, 1'b0};
    directed = '{
      '{'{12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0, 12'sd0}, 1'b1, zero_deg},
      '{'{12'sd0, 12'sd0, 12'sd2, 12'sd0, 12'sd0, 12'sd2}, 1'b1,
        '{256, 256, 362, 1'b0, 1'b0}},
      '{'{12'sd1, 12'sd1, 12'sd2, 12'sd2, 12'sd3, 12'sd3}, 1'b1, zero_deg},
      '{'{-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048, -12'sd2048},
        1'b1, zero_deg},
      '{'{-12'sd2048, -12'sd2048, 12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047},
        1'b0, zero_deg},
      '{'{12'sd2047, 12'sd2047, -12'sd2048, 12'sd2047, 12'sd2047, -12'sd2048},
        1'b0, zero_deg},
      '{'{-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 12'sd2047, 12'sd2046},
        1'b0, zero_deg},
      '{'{12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047, -12'sd2047, 12'sd2047},
        1'b0, zero_deg},
      '{'{-12'sd2048, 12'sd0, 12'sd2047, 12'sd1, 12'sd0, 12'sd0}, 1'b0, zero_deg},
      '{'{12'sd0, 12'sd0, 12'sd1, 12'sd0, 12'sd0, 12'sd1}, 1'b0, zero_deg},
      '{'{12'sd0, 12'sd0, 12'sd3, 12'sd0, 12'sd0, 12'sd7}, 1'b0, zero_deg},
      '{'{-12'sd1, -12'sd1, -12'sd1, 12'sd1, 12'sd1, -12'sd1}, 1'b0, zero_deg},
      '{'{12'sd0, 12'sd0, 12'sd2047, 12'sd0, -12'sd2048, 12'sd1}, 1'b0, zero_deg},
      '{'{12'sd5, 12'sd5, 12'sd5, 12'sd5, 12'sd9, 12'sd1}, 1'b1, zero_deg},
      '{'{12'sd0, -12'sd2048, 12'sd1, 12'sd2047, -12'sd1, 12'sd2047}, 1'b0, zero_deg}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = phase == 0 ? 24 : (phase == 1 ? 71 : 0);
      snk_stall_pct = phase == 0 ? 71 : (phase == 1 ? 24 : 0);
      if (phase == 0) begin
        foreach (directed[i]) begin
          send_triangle(directed[i].v);
        end
      end
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        random_triangle(v);
        send_triangle(v);
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow the pipeline latency for stray beats.
    wait_cycles = 0;
    while (pending_circles.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (120) @(posedge clk);
    if (mismatches == 0 && pending_circles.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Directed rows marked typed are also checked against the values typed in.
  always @(posedge clk) begin
    static int row = 0;
    if (!rst && in_valid && !in_stall && row < directed.size()) begin
      if (directed[row].typed) begin
        circle_t p;
        p = circumcircle(directed[row].v);
        if (p != directed[row].want) report("typed row", row, row);
      end
      row++;
    end
  end

endmodule
